// ===== design/arpc_pkg.sv =====
package arpc_pkg;

    // Input item: a received ARP header or a cache lookup query.
    typedef struct packed {
        logic        cmd;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [15:0] arp_op;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] query_ip;
    } t_in_item;

    // Result item: a reply to transmit or a lookup answer.
    typedef struct packed {
        logic        kind;
        logic [1:0]  learn_status;
        logic [47:0] target_mac;
        logic [31:0] target_ip;
        logic        lookup_hit;
        logic [47:0] lookup_mac;
    } t_out_item;

    // One cache entry as it is stored in the RAM.
    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] ip;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Strobes from the controller to the entry RAM.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_ram_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_DONE
    } t_state;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [1:0] LS_ADDED   = 2'd0;
    localparam logic [1:0] LS_PRESENT = 2'd1;
    localparam logic [1:0] LS_FULL    = 2'd2;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 2'd1;

endpackage

// ===== design/arpc_ram.sv =====
module arpc_ram #(
    parameter int W     = 80,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [W-1:0]  i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [W-1:0]  o_rd_data
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/arpc_ctrl.sv =====
module arpc_ctrl import arpc_pkg::*; #(
    parameter int ENTRIES = 16,
    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CW     = $clog2(ENTRIES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    output t_ram_ctl           o_ram_ctl,
    output logic [AW-1:0]      o_rd_addr,
    output logic [AW-1:0]      o_wr_addr,
    output logic [ENTRY_W-1:0] o_wr_data,
    input  logic [ENTRY_W-1:0] i_rd_data
);

    t_state    r_state, n_state;
    t_in_item  r_item;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic      r_issuing;
    logic      r_cmp_valid;
    logic      r_cmp_last;
    logic [1:0]  r_status;
    logic        r_hit;
    logic [47:0] r_mac;
    logic        r_out_valid;
    t_out_item   r_out;

    t_entry rd_entry;
    logic   accept;
    logic   in_is_req;
    logic   full;
    logic   empty;
    logic   last_issue;
    logic   found;
    logic   out_load;
    logic [31:0] key_ip;

    assign rd_entry   = t_entry'(i_rd_data);
    assign accept     = i_in_valid && o_in_ready;
    assign in_is_req  = (i_in_item.arp_op == OP_REQUEST) && (i_in_item.hw_type == HW_ETHERNET)
                        && (i_in_item.proto_type == PROTO_IPV4);
    assign full       = (r_count >= CW'(ENTRIES));
    assign empty      = (r_count == '0);
    assign last_issue = ((CW'(r_idx) + CW'(1)) == r_count);
    assign key_ip     = (r_item.cmd == CMD_LOOKUP) ? r_item.query_ip : r_item.sender_ip;
    assign found      = r_cmp_valid && (rd_entry.ip == key_ip);

    // Output decode.
    always_comb begin
        o_in_ready        = 1'b0;
        o_ram_ctl.rd_en   = 1'b0;
        o_ram_ctl.wr_en   = 1'b0;
        out_load          = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_SCAN:  o_ram_ctl.rd_en = r_issuing;
            S_WRITE: o_ram_ctl.wr_en = 1'b1;
            S_DONE:  out_load = !r_out_valid || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign o_rd_addr = r_idx;
    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = {r_item.sender_mac, r_item.sender_ip};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_item.cmd == CMD_LOOKUP) begin
                        n_state = empty ? S_DONE : S_SCAN;
                    end else if (in_is_req) begin
                        if (full) begin
                            n_state = S_DONE;
                        end else if (empty) begin
                            n_state = S_WRITE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    n_state = S_DONE;
                end else if (r_cmp_valid && r_cmp_last) begin
                    n_state = (r_item.cmd == CMD_LOOKUP) ? S_DONE : S_WRITE;
                end
            end
            S_WRITE: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_issuing   <= 1'b0;
            r_cmp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_issuing   <= 1'b1;
                r_cmp_valid <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_cmp_valid <= r_issuing;
                r_issuing   <= r_issuing && !last_issue;
            end
            if (r_state == S_WRITE) begin
                r_count <= r_count + CW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item   <= i_in_item;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_mac    <= '0;
            r_status <= full ? LS_FULL : LS_ADDED;
        end else if (r_state == S_SCAN) begin
            if (r_issuing) begin
                r_idx      <= r_idx + AW'(1);
                r_cmp_last <= last_issue;
            end
            // The pipelined reads may run past a match; the state moves on at once.
            if (found) begin
                r_status <= LS_PRESENT;
                r_hit    <= 1'b1;
                r_mac    <= rd_entry.mac;
            end
        end
        if (out_load) begin
            if (r_item.cmd == CMD_LOOKUP) begin
                r_out.kind         <= KIND_LOOKUP;
                r_out.learn_status <= LS_ADDED;
                r_out.target_mac   <= '0;
                r_out.target_ip    <= '0;
                r_out.lookup_hit   <= r_hit;
                r_out.lookup_mac   <= r_mac;
            end else begin
                r_out.kind         <= KIND_REPLY;
                r_out.learn_status <= r_status;
                r_out.target_mac   <= r_item.sender_mac;
                r_out.target_ip    <= r_item.sender_ip;
                r_out.lookup_hit   <= 1'b0;
                r_out.lookup_mac   <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== design/arp_responder_with_cache_core.sv =====
// ARP responder with a learning address cache.
// The input channel (i_in_valid/o_in_ready, i_in_item) takes either the header fields
// of a received ARP packet or a lookup query for an IPv4 address. An Ethernet/IPv4
// ARP request is learned into the cache if it is new and the cache is not full, and is
// answered with one reply request on the output channel (o_out_valid/i_out_ready,
// o_out_item); other packets give nothing. A lookup gives one answer with hit flag
// and stored MAC. Entries live in one RAM with a registered read. A lookup, or a
// request while the cache is not full, scans the stored entries one read a cycle,
// stopping at a match. One item is worked on at a time; the next is taken once the
// result is in the output register, so a stalled receiver holds the block only after
// a second result is ready.
// The configuration channel (i_cfg_valid/o_cfg_ready) is always ready and sets the own
// MAC and IP at index 0 and 1; other indexes are ignored.
// Reset empties the cache at once by clearing the entry count; RAM contents are not
// cleared, and only entries below the count are ever read.
module arp_responder_with_cache_core import arpc_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;

    t_ram_ctl            ram_ctl;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic [ENTRY_W-1:0]  rd_data;

    assign o_cfg_ready = 1'b1;

    // Own addresses set by the configuration channel are held here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_OWN_MAC) begin
                r_own_mac <= i_cfg_data[47:0];
            end else if (i_cfg_index == CFG_OWN_IP) begin
                r_own_ip <= i_cfg_data[31:0];
            end
        end
    end

    arpc_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_ram_ctl   (ram_ctl),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_rd_data   (rd_data)
    );

    arpc_ram #(
        .W     (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_ctl.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (ram_ctl.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

`ifndef NO_ASSERTIONS
    a_cfg_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_OWN_MAC)
        |=> (r_own_mac == $past(i_cfg_data[47:0])))
        else $error("own MAC not taken from configuration write");

    a_cfg_ip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_OWN_IP)
        |=> (r_own_ip == $past(i_cfg_data[31:0])))
        else $error("own IP not taken from configuration write");

    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.cmd == CMD_LOOKUP) |=> !o_in_ready)
        else $error("lookup accepted but block did not go busy");

    a_lookup_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind == KIND_LOOKUP)
        |-> (o_out_item.learn_status == LS_ADDED && o_out_item.target_mac == '0
             && o_out_item.target_ip == '0
             && (o_out_item.lookup_hit || o_out_item.lookup_mac == '0)))
        else $error("lookup answer carries stray fields");

    a_reply_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind == KIND_REPLY)
        |-> (!o_out_item.lookup_hit && o_out_item.lookup_mac == '0
             && o_out_item.learn_status != 2'd3))
        else $error("reply carries lookup fields or bad status");
`endif

endmodule

// ===== dv/arp_responder_with_cache_core_checker.sv =====
module arp_responder_with_cache_core_checker import arpc_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the address cache and the station identity.
    logic [47:0] cache_mac [ENTRIES];
    logic [31:0] cache_ip [ENTRIES];
    int          cache_count;
    logic [47:0] own_mac;
    logic [31:0] own_ip;

    // Answers owed by the block, oldest first.
    t_out_item   answer_q [$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        cache_count = 0;
    end

    task automatic flag_error(input string text);
        $display("%0t checker: %s", $time, text);
        o_fail_count++;
    endtask

    function automatic logic [1:0] learn_entry(input logic [47:0] mac, input logic [31:0] ip);
        // A full cache wins over the duplicate test.
        if (cache_count >= ENTRIES) return LS_FULL;
        for (int i = 0; i < cache_count; i++) begin
            if (cache_ip[i] == ip) return LS_PRESENT;
        end
        cache_mac[cache_count] = mac;
        cache_ip[cache_count] = ip;
        cache_count++;
        return LS_ADDED;
    endfunction

    function automatic t_out_item look_up(input logic [31:0] ip);
        t_out_item res;
        res = '0;
        res.kind = KIND_LOOKUP;
        for (int i = 0; i < cache_count; i++) begin
            if (cache_ip[i] == ip) begin
                res.lookup_hit = 1'b1;
                res.lookup_mac = cache_mac[i];
                return res;
            end
        end
        return res;
    endfunction

    task automatic compare_answer(input t_out_item got, input t_out_item want);
        if (got.kind !== want.kind)
            flag_error($sformatf("kind %h, expected %h", got.kind, want.kind));
        if (got.learn_status !== want.learn_status)
            flag_error($sformatf("learn_status %h, expected %h",
                                 got.learn_status, want.learn_status));
        if (got.target_mac !== want.target_mac)
            flag_error($sformatf("target_mac %h, expected %h", got.target_mac, want.target_mac));
        if (got.target_ip !== want.target_ip)
            flag_error($sformatf("target_ip %h, expected %h", got.target_ip, want.target_ip));
        if (got.lookup_hit !== want.lookup_hit)
            flag_error($sformatf("lookup_hit %h, expected %h", got.lookup_hit, want.lookup_hit));
        if (got.lookup_mac !== want.lookup_mac)
            flag_error($sformatf("lookup_mac %h, expected %h", got.lookup_mac, want.lookup_mac));
    endtask

    always @(posedge i_clk) begin
        t_out_item reply;
        if (!i_rst_n) begin
            cache_count = 0;
            own_mac = '0;
            own_ip = '0;
            answer_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_OWN_MAC) own_mac = i_cfg_data;
                else if (i_cfg_index == CFG_OWN_IP) own_ip = i_cfg_data[31:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (answer_q.size() == 0)
                    flag_error($sformatf("result with nothing expected: %h", i_out_item));
                else
                    compare_answer(i_out_item, answer_q.pop_front());
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_item.cmd == CMD_LOOKUP) begin
                    answer_q.push_back(look_up(i_in_item.query_ip));
                end else if (i_in_item.hw_type == HW_ETHERNET &&
                             i_in_item.proto_type == PROTO_IPV4 &&
                             i_in_item.arp_op == OP_REQUEST) begin
                    reply = '0;
                    reply.kind = KIND_REPLY;
                    reply.learn_status = learn_entry(i_in_item.sender_mac, i_in_item.sender_ip);
                    reply.target_mac = i_in_item.sender_mac;
                    reply.target_ip = i_in_item.sender_ip;
                    answer_q.push_back(reply);
                end
            end
        end
        o_pending = answer_q.size();
    end

endmodule

// ===== dv/arp_responder_with_cache_core_tb.sv =====
module arp_responder_with_cache_core_tb import arpc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES      = 16;
    localparam int POOL_SIZE    = 24;
    localparam int DRAIN_CYCLES = ENTRIES + 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_ITEMS  = 380;

    // Indexes that map to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    fail_count;
    int                    results_owed;
    int                    hold_requests;
    int                    hold_served;
    logic [31:0]           ip_pool [POOL_SIZE];

    arp_responder_with_cache_core #(
        .ENTRIES (ENTRIES)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    arp_responder_with_cache_core_checker #(
        .ENTRIES (ENTRIES)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (results_owed)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic logic [31:0] pool_or_random();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic t_in_item arp_packet(input logic [15:0] hw, input logic [15:0] proto,
                                            input logic [15:0] op, input logic [47:0] mac,
                                            input logic [31:0] ip);
        t_in_item it;
        it.cmd = CMD_PACKET;
        it.hw_type = hw;
        it.proto_type = proto;
        it.arp_op = op;
        it.sender_mac = mac;
        it.sender_ip = ip;
        it.query_ip = $urandom;
        return it;
    endfunction

    // The packet fields of a query are filled with noise; the block must ignore them.
    function automatic t_in_item ip_query(input logic [31:0] ip);
        t_in_item it;
        it = arp_packet(16'($urandom), 16'($urandom), 16'($urandom), rand48(), $urandom);
        it.cmd = CMD_LOOKUP;
        it.query_ip = ip;
        return it;
    endfunction

    function automatic t_in_item random_item(output bit answered);
        t_in_item it;
        int r;
        int b;
        r = $urandom_range(0, 99);
        answered = 1'b1;
        if (r < 35) begin
            it = arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand48(), pool_or_random());
        end else if (r < 70) begin
            it = ip_query(pool_or_random());
        end else if (r < 88) begin
            // Almost a request: one header field is off.
            it = arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand48(), pool_or_random());
            answered = 1'b0;
            b = $urandom_range(0, 15);
            case ($urandom_range(0, 3))
                0: it.hw_type[b] = ~it.hw_type[b];
                1: it.proto_type[b] = ~it.proto_type[b];
                2: it.arp_op[b] = ~it.arp_op[b];
                default: it.arp_op = 16'd2;
            endcase
        end else begin
            it = arp_packet(16'($urandom), 16'($urandom), 16'($urandom), rand48(), $urandom);
            answered = 1'b0;
        end
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken,
    // with valid still high.
    task automatic send_request(input t_in_item it, input int gap);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item = it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_traffic(input int count, input bit back_to_back);
        int sent;
        t_in_item it;
        bit answered;
        sent = 0;
        while (sent < count) begin
            it = random_item(answered);
            send_request(it, back_to_back ? 0 : pick_gap());
            if (answered) sent++;
        end
    endtask

    // Waits until no answer is owed, then lets the block idle with no input.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (results_owed != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(input logic [47:0] mac, input logic [31:0] ip,
                             input logic [CFG_IDX_W-1:0] spare);
        write_reg(CFG_OWN_MAC, mac);
        write_reg(CFG_OWN_IP, {16'($urandom), ip});
        write_reg(spare, rand48());
        cfg_valid = 1'b0;
    endtask

    // Receiver: random ready pattern, plus long hold-offs on demand.
    initial begin
        int low_left;
        int high_left;
        low_left = 0;
        high_left = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                if (low_left == 0 && high_left == 0) begin
                    low_left = pick_gap();
                    high_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 8);
                end
                if (low_left > 0) begin
                    out_ready = 1'b0;
                    low_left--;
                end else begin
                    out_ready = 1'b1;
                    high_left--;
                end
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_in_item it;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_requests = 0;
        hold_served = 0;
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hffff_ffff;
        for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        configure('1, '0, CFG_SPARE_A);

        // Directed: empty cache, rejected headers, learning, duplicates, lookups.
        send_request(ip_query(32'h0000_0000), pick_gap());
        send_request(ip_query(32'hffff_ffff), pick_gap());
        send_request(arp_packet(HW_ETHERNET, PROTO_IPV4, 16'd2, rand48(), $urandom), 0);
        send_request(arp_packet(16'h0000, PROTO_IPV4, OP_REQUEST, rand48(), $urandom), 0);
        send_request(arp_packet(16'hffff, PROTO_IPV4, OP_REQUEST, rand48(), $urandom), 0);
        send_request(arp_packet(HW_ETHERNET, 16'h0000, OP_REQUEST, rand48(), $urandom), 0);
        send_request(arp_packet(HW_ETHERNET, 16'hffff, OP_REQUEST, rand48(), $urandom), 0);
        send_request(arp_packet(HW_ETHERNET, PROTO_IPV4, 16'h0000, rand48(), $urandom), 0);
        send_request(arp_packet(HW_ETHERNET, PROTO_IPV4, 16'hffff, rand48(), $urandom), 0);
        send_request(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, '0, ip_pool[0]), 0);
        send_request(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, '1, ip_pool[1]), 0);
        // Same IP again with a new MAC: the stored MAC must stay.
        send_request(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand48(), ip_pool[0]), 0);
        send_request(ip_query(ip_pool[0]), 0);
        send_request(ip_query(ip_pool[1]), pick_gap());
        // A query that carries a valid request header is still only a query.
        it = arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand48(), ip_pool[2]);
        it.cmd = CMD_LOOKUP;
        it.query_ip = ip_pool[1];
        send_request(it, 0);
        send_request(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand48(), ip_pool[2]), 0);
        send_request(ip_query(ip_pool[2]), 0);
        send_request(ip_query(ip_pool[3]), pick_gap());

        run_traffic(PHASE_ITEMS, 1'b0);
        wait_drained();
        configure('0, '1, CFG_SPARE_B);

        // Stall the output long enough for the block to back up into its input.
        hold_requests++;
        run_traffic(15, 1'b1);
        run_traffic(PHASE_ITEMS, 1'b0);
        wait_drained();
        configure(rand48(), $urandom, CFG_SPARE_A);

        run_traffic(PHASE_ITEMS, 1'b0);
        wait_drained();

        if (fail_count == 0 && results_owed == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/arpc_pkg.sv
design/arpc_ram.sv
design/arpc_ctrl.sv
design/arp_responder_with_cache_core.sv
dv/arp_responder_with_cache_core_checker.sv
dv/arp_responder_with_cache_core_tb.sv
